@@ sv/sorted_deadline_timer_queue_core_assert.svh @@
// Assertion macros shared by the checker of the sorted deadline timer queue.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_CORE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock and idle during reset.
`define SDTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock and idle during reset.
`define SDTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sdtq_pkg.sv @@
// Package with the types, codes and helper function of the sorted deadline timer queue.
package sdtq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int ID_W           = 6;
    localparam int NUM_IDS        = 1 << ID_W;
    localparam int TIME_W         = 63;
    localparam int WAIT_W         = 31;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_POLL   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Contents of one cell of the queue.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
    } t_entry;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic              ins;
        logic              rm;
        logic              pop;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
    } t_cell_ctl;

    // Ticks from now until the deadline, saturated; only meaningful when the
    // deadline lies after now.
    function automatic logic [WAIT_W-1:0] sat_wait(input logic [TIME_W-1:0] deadline,
                                                   input logic [TIME_W-1:0] now);
        logic [TIME_W:0] diff;
        diff = {1'b0, deadline} - {1'b0, now};
        if (diff[TIME_W:WAIT_W] != '0) begin
            return '1;
        end
        return diff[WAIT_W-1:0];
    endfunction

endpackage

@@ sv/sdtq_cell.sv @@
// One cell of the sorted timer chain: holds one timer and shifts with its neighbours.
module sdtq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdtq_pkg::t_cell_ctl i_ctl,
    input  sdtq_pkg::t_entry  i_left,
    input  sdtq_pkg::t_entry  i_right,
    input  logic              i_left_keep,
    input  logic              i_left_hit,
    output sdtq_pkg::t_entry  o_entry,
    output logic              o_keep,
    output logic              o_hit
);

    logic                          r_valid;
    logic [sdtq_pkg::ID_W-1:0]     r_id;
    logic [sdtq_pkg::TIME_W-1:0]   r_deadline;
    sdtq_pkg::t_entry              n_entry;
    sdtq_pkg::t_entry              w_new;
    logic                          w_match;

    assign o_entry = '{valid: r_valid, id: r_id, deadline: r_deadline};
    assign o_keep  = r_valid && (r_deadline <= i_ctl.deadline);
    assign w_match = r_valid && (r_id == i_ctl.id);
    assign o_hit   = i_left_hit || w_match;
    assign w_new   = '{valid: 1'b1, id: i_ctl.id, deadline: i_ctl.deadline};

    // A timer stays put when it is due no later than the new one; the first
    // cell that does not stay takes the new timer and the rest move right.
    always_comb begin
        n_entry = o_entry;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                n_entry = i_left_keep ? w_new : i_left;
            end
        end else if (i_ctl.rm) begin
            if (o_hit) begin
                n_entry = i_right;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_id       <= n_entry.id;
        r_deadline <= n_entry.deadline;
    end

endmodule

@@ sv/sorted_deadline_timer_queue_core.sv @@
// Top level of the sorted deadline timer queue: cell chain, id flags and result register.
//
//  Channel   Handshake                 Payload
//  request   start in, busy out        i_req_type, i_timer_id, i_deadline, i_current_time
//  result    o_strobe out, no stall    o_fired_id, o_fired_valid, o_wait_ticks,
//                                      o_queue_empty, o_status, o_last
//
// Adds, removes and the unused request code give a single result in the cycle
// after the transaction; busy stays low throughout. A poll gives one result per
// timer that fires, or one if none fires, and holds busy high until its last
// result is formed. Its first result passes the state register, then the
// result register; the rest follow one per cycle, as the head is compared and popped.
// Synchronous reset clears the cells, id flags, state and strobe; results never stall.
module sorted_deadline_timer_queue_core #(
    parameter int NUM_TIMERS = sdtq_pkg::NUM_TIMERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic [sdtq_pkg::ID_W-1:0]     i_timer_id,
    input  logic [sdtq_pkg::TIME_W-1:0]   i_deadline,
    input  logic [sdtq_pkg::TIME_W-1:0]   i_current_time,
    output logic                          o_strobe,
    output logic [sdtq_pkg::ID_W-1:0]     o_fired_id,
    output logic                          o_fired_valid,
    output logic [sdtq_pkg::WAIT_W-1:0]   o_wait_ticks,
    output logic                          o_queue_empty,
    output logic [1:0]                    o_status,
    output logic                          o_last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POLL = 1'b1;

    logic                           r_state;
    logic                           n_state;
    logic [sdtq_pkg::TIME_W-1:0]    r_now;
    logic [sdtq_pkg::NUM_IDS-1:0]   r_id_pending;
    logic [sdtq_pkg::NUM_IDS-1:0]   n_id_pending;

    logic                           r_strobe;
    logic [sdtq_pkg::ID_W-1:0]      r_fired_id;
    logic                           r_fired_valid;
    logic [sdtq_pkg::WAIT_W-1:0]    r_wait;
    logic                           r_empty;
    logic [1:0]                     r_status;
    logic                           r_last;
    logic                           n_strobe;
    logic [sdtq_pkg::ID_W-1:0]      n_fired_id;
    logic                           n_fired_valid;
    logic [sdtq_pkg::WAIT_W-1:0]    n_wait;
    logic                           n_empty;
    logic [1:0]                     n_status;
    logic                           n_last;

    sdtq_pkg::t_cell_ctl            w_ctl;
    sdtq_pkg::t_entry               w_entry [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]          w_keep;
    logic [NUM_TIMERS-1:0]          w_hit;

    logic                           w_accept;
    logic                           w_id_flag;
    logic                           w_full;
    logic                           w_fire0;
    logic                           w_fire1;
    sdtq_pkg::t_entry               w_next;

    // The chain: each cell sees its left and right neighbours; the ends see
    // an empty entry. The match flag of a remove ripples to the right so
    // that every cell after the matching one moves left.
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        sdtq_pkg::t_entry w_left;
        sdtq_pkg::t_entry w_right;
        logic             w_left_keep;
        logic             w_left_hit;

        if (g == 0) begin : g_first
            assign w_left      = '0;
            assign w_left_keep = 1'b1;
            assign w_left_hit  = 1'b0;
        end else begin : g_inner
            assign w_left      = w_entry[g-1];
            assign w_left_keep = w_keep[g-1];
            assign w_left_hit  = w_hit[g-1];
        end

        if (g == NUM_TIMERS - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        sdtq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_left_keep (w_left_keep),
            .i_left_hit  (w_left_hit),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g]),
            .o_hit       (w_hit[g])
        );
    end

    assign busy      = (r_state == S_POLL);
    assign w_accept  = start && !busy;
    assign w_id_flag = r_id_pending[i_timer_id];
    // The chain fills from the front, so the last cell holding a timer
    // means that the queue is full.
    assign w_full    = w_entry[NUM_TIMERS-1].valid;

    // Poll step: the head fires when due; the cell behind it decides whether
    // this is the final result of the poll and, when the head fires, supplies the wait.
    assign w_fire0 = w_entry[0].valid && (w_entry[0].deadline <= r_now);
    assign w_fire1 = w_entry[1].valid && (w_entry[1].deadline <= r_now);
    assign w_next  = w_fire0 ? w_entry[1] : w_entry[0];

    always_comb begin
        w_ctl          = '0;
        w_ctl.id       = i_timer_id;
        w_ctl.deadline = i_deadline;
        n_state        = r_state;
        n_id_pending   = r_id_pending;
        n_strobe       = 1'b0;
        n_fired_id     = '0;
        n_fired_valid  = 1'b0;
        n_wait         = '0;
        n_empty        = 1'b0;
        n_status       = sdtq_pkg::ST_OK;
        n_last         = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_strobe = 1'b1;
                    unique case (i_req_type)
                        sdtq_pkg::REQ_ADD: begin
                            // A refused add leaves a non-empty queue, and a
                            // taken one adds a timer to it, so the queue is never empty.
                            if (w_id_flag || w_full) begin
                                n_status = sdtq_pkg::ST_REFUSED;
                            end else begin
                                w_ctl.ins                = 1'b1;
                                n_id_pending[i_timer_id] = 1'b1;
                            end
                        end
                        sdtq_pkg::REQ_REMOVE: begin
                            if (w_id_flag) begin
                                w_ctl.rm                 = 1'b1;
                                n_id_pending[i_timer_id] = 1'b0;
                                n_empty                  = !w_entry[1].valid;
                            end else begin
                                n_status = sdtq_pkg::ST_MISSING;
                                n_empty  = !w_entry[0].valid;
                            end
                        end
                        sdtq_pkg::REQ_POLL: begin
                            n_strobe = 1'b0;
                            n_state  = S_POLL;
                        end
                        default: begin
                            n_empty = !w_entry[0].valid;
                        end
                    endcase
                end
            end
            S_POLL: begin
                n_strobe = 1'b1;
                if (w_fire0) begin
                    w_ctl.pop                      = 1'b1;
                    n_id_pending[w_entry[0].id]    = 1'b0;
                    n_fired_id                     = w_entry[0].id;
                    n_fired_valid                  = 1'b1;
                    n_last                         = !w_fire1;
                end
                if (n_last) begin
                    n_state = S_IDLE;
                    n_empty = !w_next.valid;
                    if (w_next.valid) begin
                        n_wait = sdtq_pkg::sat_wait(w_next.deadline, r_now);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_id_pending <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_id_pending <= n_id_pending;
            r_strobe     <= n_strobe;
        end
        if (w_accept) begin
            r_now <= i_current_time;
        end
        r_fired_id    <= n_fired_id;
        r_fired_valid <= n_fired_valid;
        r_wait        <= n_wait;
        r_empty       <= n_empty;
        r_status      <= n_status;
        r_last        <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_fired_id    = r_fired_id;
    assign o_fired_valid = r_fired_valid;
    assign o_wait_ticks  = r_wait;
    assign o_queue_empty = r_empty;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

@@ sv/sdtq_checker.sv @@
// Port checker for the sorted deadline timer queue, bound to the top level.
`include "sorted_deadline_timer_queue_core_assert.svh"

module sdtq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    i_req_type,
    input logic                          o_strobe,
    input logic                          o_fired_valid,
    input logic [sdtq_pkg::WAIT_W-1:0]   o_wait_ticks,
    input logic                          o_queue_empty,
    input logic [1:0]                    o_status,
    input logic                          o_last
);

    // Adds, removes and unused codes answer in the very next cycle.
    `SDTQ_ASSERT_NEXT(a_quick_reply, start && !busy && i_req_type != sdtq_pkg::REQ_POLL, o_strobe, "no result after a single-cycle request")

    // A result with no fired timer always closes its request.
    `SDTQ_ASSERT_NOW(a_idle_result_last, o_strobe && !o_fired_valid, o_last, "result without a fired timer is not the last")

    // While a poll still owes results, the block must refuse new requests.
    `SDTQ_ASSERT_NOW(a_more_means_busy, o_strobe && !o_last, busy, "poll results pending but not busy")

    // An empty queue has no next deadline to wait for and never follows a refused add.
    `SDTQ_ASSERT_NOW(a_empty_no_wait, o_strobe && o_queue_empty, o_wait_ticks == '0 && o_status != sdtq_pkg::ST_REFUSED, "empty queue reported with a wait or a refused add")

endmodule

bind sorted_deadline_timer_queue_core sdtq_checker u_sdtq_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking testbench of the sorted deadline timer queue core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W    = sdtq_pkg::ID_W;
    localparam int NUM_IDS = sdtq_pkg::NUM_IDS;
    localparam int TIME_W  = sdtq_pkg::TIME_W;
    localparam int WAIT_W  = sdtq_pkg::WAIT_W;

    // The package names three request codes; the fourth is accepted and leaves the queue as it is.
    localparam logic [1:0] REQ_NOP = 2'd3;

    localparam int DEPTH = sdtq_pkg::NUM_TIMERS_DEF;

    localparam logic [TIME_W-1:0] TIME_MAX   = '1;
    localparam logic [TIME_W-1:0] WAIT_LIMIT = 63'h7FFF_FFFF;

    // One result transaction as the core presents it.
    typedef struct packed {
        logic [ID_W-1:0]   fired_id;
        logic              fired_valid;
        logic [WAIT_W-1:0] wait_ticks;
        logic              queue_empty;
        logic [1:0]        status;
        logic              last;
    } t_timer_result;

    logic                clk_gen;
    logic                i_clk;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic [1:0]          i_req_type     = REQ_NOP;
    logic [ID_W-1:0]     i_timer_id     = '0;
    logic [TIME_W-1:0]   i_deadline     = '0;
    logic [TIME_W-1:0]   i_current_time = '0;
    logic                o_strobe;
    logic [ID_W-1:0]     o_fired_id;
    logic                o_fired_valid;
    logic [WAIT_W-1:0]   o_wait_ticks;
    logic                o_queue_empty;
    logic [1:0]          o_status;
    logic                o_last;

    // Results that the accepted requests are still owed, oldest first.
    t_timer_result       expected_results[$];

    // Shadow of the timer queue: slots in deadline order and one armed flag per id.
    logic [ID_W-1:0]     slot_ids[DEPTH];
    logic [TIME_W-1:0]   slot_deadlines[DEPTH];
    int                  armed_count = 0;
    logic [NUM_IDS-1:0]  id_armed    = '0;

    int                  error_count  = 0;
    bit                  idle_enabled = 1'b0;
    // Base of the id window that random traffic mostly draws from.
    logic [ID_W-1:0]     id_window    = '0;
    // Notional present time that random deadlines and polls are built around.
    logic [TIME_W-1:0]   sim_ticks    = '0;

    sorted_deadline_timer_queue_core #(
        .NUM_TIMERS     (DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_timer_id     (i_timer_id),
        .i_deadline     (i_deadline),
        .i_current_time (i_current_time),
        .o_strobe       (o_strobe),
        .o_fired_id     (o_fired_id),
        .o_fired_valid  (o_fired_valid),
        .o_wait_ticks   (o_wait_ticks),
        .o_queue_empty  (o_queue_empty),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    assign i_clk = clk_gen;

    initial begin
        clk_gen = 1'b0;
        forever #5 clk_gen = ~clk_gen;
    end

    // Safety net: the slowest legal run is well under a tenth of this.
    initial begin
        #2_000_000;
        $display("sorted_deadline_timer_queue_core test failed");
        $finish;
    end

    // Every problem found is reported on one line and counted here.
    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Closes the gap left by a fired or removed timer so the slots stay packed.
    function automatic void drop_slot(input int pos);
        int i;
        for (i = pos; i + 1 < armed_count; i++) begin
            slot_ids[i]       = slot_ids[i + 1];
            slot_deadlines[i] = slot_deadlines[i + 1];
        end
        armed_count--;
    endfunction

    // Applies one accepted request to the shadow queue and queues the results it owes.
    function automatic void predict_timer_results(input logic [1:0]        req,
                                                  input logic [ID_W-1:0]   id,
                                                  input logic [TIME_W-1:0] dl,
                                                  input logic [TIME_W-1:0] now);
        t_timer_result     res;
        logic [TIME_W-1:0] gap;
        int                pos;
        int                i;
        int                fired;

        res      = '0;
        res.last = 1'b1;
        case (req)
            sdtq_pkg::REQ_ADD: begin
                if (id_armed[id] || armed_count >= DEPTH) begin
                    res.status = sdtq_pkg::ST_REFUSED;
                end else begin
                    // A new timer goes behind every timer due at or before it.
                    pos = 0;
                    while (pos < armed_count && slot_deadlines[pos] <= dl) begin
                        pos++;
                    end
                    for (i = armed_count; i > pos; i--) begin
                        slot_ids[i]       = slot_ids[i - 1];
                        slot_deadlines[i] = slot_deadlines[i - 1];
                    end
                    slot_ids[pos]       = id;
                    slot_deadlines[pos] = dl;
                    armed_count++;
                    id_armed[id] = 1'b1;
                end
                res.queue_empty = (armed_count == 0);
                expected_results.push_back(res);
            end
            sdtq_pkg::REQ_REMOVE: begin
                res.status = sdtq_pkg::ST_MISSING;
                if (id_armed[id]) begin
                    for (i = 0; i < armed_count; i++) begin
                        if (slot_ids[i] == id) begin
                            drop_slot(i);
                            break;
                        end
                    end
                    id_armed[id] = 1'b0;
                    res.status   = sdtq_pkg::ST_OK;
                end
                res.queue_empty = (armed_count == 0);
                expected_results.push_back(res);
            end
            sdtq_pkg::REQ_POLL: begin
                fired = 0;
                while (armed_count > 0 && slot_deadlines[0] <= now) begin
                    res             = '0;
                    res.fired_id    = slot_ids[0];
                    res.fired_valid = 1'b1;
                    id_armed[slot_ids[0]] = 1'b0;
                    drop_slot(0);
                    expected_results.push_back(res);
                    fired++;
                end
                // The closing result is the last fired timer, or a bare one if none fired.
                if (fired > 0) begin
                    res = expected_results.pop_back();
                end else begin
                    res = '0;
                end
                res.last        = 1'b1;
                res.queue_empty = (armed_count == 0);
                if (armed_count > 0) begin
                    gap = slot_deadlines[0] - now;
                    res.wait_ticks = (gap > WAIT_LIMIT) ? WAIT_LIMIT[WAIT_W-1:0]
                                                        : gap[WAIT_W-1:0];
                end
                expected_results.push_back(res);
            end
            default: begin
                res.queue_empty = (armed_count == 0);
                expected_results.push_back(res);
            end
        endcase
    endfunction

    // Matches one result transaction against the oldest outstanding expectation.
    task automatic check_result();
        t_timer_result want;
        if (expected_results.size() == 0) begin
            report_error("result transaction with nothing outstanding");
        end else begin
            want = expected_results.pop_front();
            compare_field("fired_id", 64'(o_fired_id), 64'(want.fired_id));
            compare_field("fired_valid", 64'(o_fired_valid), 64'(want.fired_valid));
            compare_field("wait_ticks", 64'(o_wait_ticks), 64'(want.wait_ticks));
            compare_field("queue_empty", 64'(o_queue_empty), 64'(want.queue_empty));
            compare_field("status", 64'(o_status), 64'(want.status));
            compare_field("last", 64'(o_last), 64'(want.last));
        end
    endtask

    // Both sides are sampled at the rising edge, before any of that edge's updates
    // land. Results are checked before the new request is predicted, so the two
    // never race for the queue of expectations.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                check_result();
            end
            if (start && !busy) begin
                predict_timer_results(i_req_type, i_timer_id, i_deadline, i_current_time);
            end
        end
    end

    function automatic logic [TIME_W-1:0] rand_ticks();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TIME_W-1:0];
    endfunction

    // Mostly ids from a window of twenty, so that timers collide and get removed,
    // now and then any id at all.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 3) == 0) begin
            return ID_W'($urandom_range(0, NUM_IDS - 1));
        end
        return id_window + ID_W'($urandom_range(0, 19));
    endfunction

    // Offers one request and holds it until the core takes the transaction. Idle
    // cycles go in front of it, which also puts gaps behind the previous request
    // while a poll is still emitting fired timers.
    task automatic send_request(input logic [1:0]        req,
                                input logic [ID_W-1:0]   id,
                                input logic [TIME_W-1:0] dl,
                                input logic [TIME_W-1:0] now);
        while (idle_enabled && $urandom_range(0, 99) < 35) begin
            start          <= 1'b0;
            i_req_type     <= 2'($urandom_range(0, 3));
            i_timer_id     <= ID_W'($urandom);
            i_deadline     <= rand_ticks();
            i_current_time <= rand_ticks();
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= req;
        i_timer_id     <= id;
        i_deadline     <= dl;
        i_current_time <= now;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    // Holds the sender back until every owed result has been seen, then lets the
    // core settle with start held low.
    task automatic wait_results_drained();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_results.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Empty queue, the unused request code, duplicate adds, removal of an absent
    // id and the extremes of id and time.
    task automatic test_empty_and_refusals();
        send_request(sdtq_pkg::REQ_POLL, '0, '0, '0);
        send_request(REQ_NOP, '1, TIME_MAX, TIME_MAX);
        send_request(sdtq_pkg::REQ_REMOVE, '1, '0, '0);
        send_request(sdtq_pkg::REQ_ADD, '0, '0, TIME_MAX);
        send_request(sdtq_pkg::REQ_ADD, '0, 63'd5, '0);
        send_request(sdtq_pkg::REQ_ADD, '1, TIME_MAX, '0);
        send_request(sdtq_pkg::REQ_POLL, '0, '0, '0);
        send_request(sdtq_pkg::REQ_REMOVE, '1, '0, '0);
        send_request(sdtq_pkg::REQ_POLL, '0, '0, TIME_MAX);
        wait_results_drained();
    endtask

    // The wait to the next deadline right at, just over and just under saturation,
    // and a poll that lands exactly on the deadline.
    task automatic test_saturated_wait();
        send_request(sdtq_pkg::REQ_ADD, 6'd42, WAIT_LIMIT + 63'd50, '0);
        send_request(sdtq_pkg::REQ_POLL, '0, '0, 63'd50);
        send_request(sdtq_pkg::REQ_POLL, '0, '0, 63'd49);
        send_request(sdtq_pkg::REQ_POLL, '0, '0, 63'd51);
        send_request(sdtq_pkg::REQ_POLL, '0, '0, WAIT_LIMIT + 63'd50);
        wait_results_drained();
    endtask

    // Fills every slot with groups of equal deadlines, tries one add too many,
    // then drains the queue in two polls that must keep insertion order.
    task automatic test_full_queue();
        int k;
        for (k = 0; k < DEPTH; k++) begin
            send_request(sdtq_pkg::REQ_ADD, ID_W'(NUM_IDS - DEPTH + k),
                         TIME_W'(200 + k / 4), '0);
        end
        send_request(sdtq_pkg::REQ_ADD, 6'd1, 63'd100, '0);
        send_request(sdtq_pkg::REQ_POLL, '0, '0, 63'd201);
        send_request(sdtq_pkg::REQ_POLL, '0, '0, TIME_MAX);
        wait_results_drained();
    endtask

    // Adds with deadlines just ahead of a slowly advancing present, removals and
    // polls that catch a few timers each; a share of wild times, saturating waits
    // and unused codes keeps every field bit moving.
    task automatic test_random_traffic(input int n_items);
        int                n;
        int                pick;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dl;
        logic [TIME_W-1:0] now;

        id_window = ID_W'($urandom);
        for (n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            id   = pick_id();
            dl   = rand_ticks();
            now  = rand_ticks();
            if (pick < 40) begin
                case ($urandom_range(0, 9))
                    0:       dl = rand_ticks();
                    1:       dl = sim_ticks + WAIT_LIMIT + TIME_W'($urandom_range(0, 3));
                    default: dl = sim_ticks + TIME_W'($urandom_range(0, 300));
                endcase
                send_request(sdtq_pkg::REQ_ADD, id, dl, now);
            end else if (pick < 65) begin
                send_request(sdtq_pkg::REQ_REMOVE, id, dl, now);
            end else if (pick < 95) begin
                if ($urandom_range(0, 9) != 0) begin
                    sim_ticks = sim_ticks + TIME_W'($urandom_range(0, 120));
                    now       = sim_ticks;
                end
                send_request(sdtq_pkg::REQ_POLL, id, dl, now);
            end else begin
                send_request(REQ_NOP, id, dl, now);
            end
            if ($urandom_range(0, 59) == 0) begin
                wait_results_drained();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_refusals();
        test_saturated_wait();
        test_full_queue();

        idle_enabled = 1'b1;
        test_random_traffic(150);
        // A long stretch of back-to-back requests.
        idle_enabled = 1'b0;
        test_random_traffic(100);
        idle_enabled = 1'b1;
        test_random_traffic(150);

        wait_results_drained();
        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (error_count == 0) begin
            $display("sorted_deadline_timer_queue_core test passed");
        end else begin
            $display("sorted_deadline_timer_queue_core test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/sdtq_pkg.sv
sv/sdtq_cell.sv
sv/sorted_deadline_timer_queue_core.sv
sv/sdtq_checker.sv
bench/tb_top.sv
